// File: rtl/core/dtcu_pkg.sv
// ---------------------------------------------------------------------------
// dtcu_pkg: shared types and constants of the diagonal trace code unpacker
// Widths, lane split and the control state type used by all core files.
// ---------------------------------------------------------------------------
package dtcu_pkg;

    // Word and code geometry (WORD_BITS is a power of two)
    localparam int WORD_BITS   = 64;
    localparam int CODES       = WORD_BITS / 2;
    localparam int LANES       = 4;
    localparam int LANE_CODES  = CODES / LANES;
    localparam int LIDX_W      = (LANE_CODES > 1) ? $clog2(LANE_CODES) : 1;
    localparam int IDX_W       = (CODES > 1) ? $clog2(CODES) : 1;
    localparam int CNT_W       = $clog2(CODES + 1);

    // Matrix limits
    localparam int MAX_QUERY   = 256;
    localparam int MAX_SUBJECT = 1024;

    // Field widths
    localparam int QL_W        = 9;
    localparam int SL_W        = 11;
    localparam int ROW_W       = 9;
    localparam int COL_W       = 11;
    localparam int CODE_W      = 2;
    localparam int DIAG_W      = 11;
    localparam int PLACED_W    = 9;
    localparam int BLK_W       = $clog2((2 * MAX_QUERY + WORD_BITS - 1) / WORD_BITS + 1);
    localparam int SUM_W       = 12;

    // Stream packing
    localparam int OUT_DATA_W  = 24;
    localparam int OUT_USER_W  = 2;

    // APB
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam logic REG_QUERY_LEN   = 1'b0;
    localparam logic REG_SUBJECT_LEN = 1'b1;

    // Result kinds carried in tuser[0]
    localparam logic ST_CELL    = 1'b0;
    localparam logic ST_OVERRUN = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HERR,
        S_SCAN,
        S_END
    } t_state;

    // First pending code found by one lane
    typedef struct packed {
        logic               found;
        logic [LIDX_W-1:0]  idx;
        logic [CODE_W-1:0]  code;
    } t_lane_hit;

    // Merged pick over all lanes
    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   idx;
        logic [CODE_W-1:0]  code;
        logic               rest;
    } t_pick;

endpackage

// File: rtl/core/diagonal_trace_code_unpacker_core.sv
// ---------------------------------------------------------------------------
// diagonal_trace_code_unpacker_core: trace code unpacker, top level
// Unpacks 64-bit words of 2-bit traceback codes into (row, col, code) cells.
// ---------------------------------------------------------------------------
// Words arrive one anti-diagonal at a time; each diagonal owns a block of
// ceil(query_len/32) words. Codes are scanned from bit 0 up, zero codes are
// padding, and each nonzero code lands on the next cell of the diagonal
// (row counts down from the start row, column counts up). One request on
// s_axis yields 0 to 32 result requests on m_axis, tlast marking the final
// one. Results leave one per cycle, while the output is not stalled, from a
// single output register. A word is taken in S_IDLE, gives its results in
// S_SCAN, which then closes the scan, and S_END does the block bookkeeping;
// an overrun report rides in the bookkeeping step. The input is taken again
// as soon as the previous word is fully scanned, even while its last result
// still waits in the output register.
// Four lanes of eight codes search for the next pending code in parallel
// and a merge stage picks the lowest. An overrun of the word block gives a
// result with tuser[0] set and restarts at diagonal 1; if the word already
// gave 32 results that error leads the next word. Writing either length
// register restarts the matrix. Writes to registers are for idle times only.
// ---------------------------------------------------------------------------
module diagonal_trace_code_unpacker_core import dtcu_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [WORD_BITS-1:0]   s_axis_tdata,   // [63:0] packed_word
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // [8:0] cell_row, [19:9] cell_col,
                                                   // [21:20] trace_code, [23:22] zero
    output logic [OUT_USER_W-1:0]  m_axis_tuser,   // [0] status, [1] matrix_done
    output logic                   m_axis_tlast,
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_AW-1:0]      paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    // ---------------- registers ----------------
    t_state               r_state,   n_state;
    logic [WORD_BITS-1:0] r_word,    n_word;
    logic [CODES-1:0]     r_pend,    n_pend;
    logic [CNT_W-1:0]     r_cnt,     n_cnt;      // results given for this word
    logic [QL_W-1:0]      r_ql,      n_ql;
    logic [SL_W-1:0]      r_sl,      n_sl;
    logic [DIAG_W-1:0]    r_diag,    n_diag;
    logic [ROW_W-1:0]     r_srow,    n_srow;
    logic [COL_W-1:0]     r_scol,    n_scol;
    logic [PLACED_W-1:0]  r_placed,  n_placed;
    logic [BLK_W-1:0]     r_wib,     n_wib;
    logic                 r_filled,  n_filled;
    logic                 r_err_held, n_err_held;
    // output register
    logic                 r_ovalid,  n_ovalid;
    logic [ROW_W-1:0]     r_orow,    n_orow;
    logic [COL_W-1:0]     r_ocol,    n_ocol;
    logic [CODE_W-1:0]    r_ocode,   n_ocode;
    logic                 r_ostat,   n_ostat;
    logic                 r_odone,   n_odone;
    logic                 r_olast,   n_olast;

    // ---------------- lanes and merge ----------------
    t_lane_hit            w_hits [LANES];
    t_pick                w_pick;
    logic [CODES-1:0]     w_pend_next;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        dtcu_lane u_lane (
            .i_codes (r_word[l*CODE_W*LANE_CODES +: CODE_W*LANE_CODES]),
            .i_pend  (r_pend[l*LANE_CODES +: LANE_CODES]),
            .o_hit   (w_hits[l])
        );
    end

    dtcu_merge u_merge (
        .i_hits      (w_hits),
        .i_pend      (r_pend),
        .o_pick      (w_pick),
        .o_pend_next (w_pend_next)
    );

    // ---------------- derived geometry ----------------
    logic [QL_W-1:0]   w_eq;        // clamped query length
    logic [SL_W-1:0]   w_es;        // clamped subject length
    logic [SUM_W-1:0]  w_bw_sum;
    logic [BLK_W-1:0]  w_bw;        // words per diagonal
    logic [SUM_W-1:0]  w_last_diag;
    logic [SUM_W-1:0]  w_right;
    logic [ROW_W-1:0]  w_cells;     // cells on the current diagonal
    logic [BLK_W:0]    w_wib_inc;
    logic              w_blk_end;
    logic [PLACED_W:0] w_placed_inc;
    logic              w_fill_now;
    logic [CNT_W:0]    w_cnt_inc;
    logic              w_slot_free;
    logic              w_apb_wr;
    logic [ROW_W-1:0]  w_row;
    logic [COL_W-1:0]  w_col;

    always_comb begin
        if (r_ql == '0)
            w_eq = QL_W'(1);
        else if (SUM_W'(r_ql) > SUM_W'(MAX_QUERY))
            w_eq = QL_W'(MAX_QUERY);
        else
            w_eq = r_ql;

        if (r_sl == '0)
            w_es = SL_W'(1);
        else if (SUM_W'(r_sl) > SUM_W'(MAX_SUBJECT))
            w_es = SL_W'(MAX_SUBJECT);
        else
            w_es = r_sl;

        // ceil(2*q / WORD_BITS)
        w_bw_sum    = (SUM_W'(w_eq) << 1) + SUM_W'(WORD_BITS - 1);
        w_bw        = BLK_W'(w_bw_sum >> $clog2(WORD_BITS));
        w_last_diag = SUM_W'(w_eq) + SUM_W'(w_es) - SUM_W'(1);

        w_right = SUM_W'(w_es) - SUM_W'(r_scol) + SUM_W'(1);
        if (SUM_W'(r_scol) > SUM_W'(w_es))
            w_cells = ROW_W'(1);
        else if (SUM_W'(r_srow) < w_right)
            w_cells = r_srow;
        else
            w_cells = ROW_W'(w_right);

        w_wib_inc    = {1'b0, r_wib} + (BLK_W+1)'(1);
        w_blk_end    = w_wib_inc >= (BLK_W+1)'(w_bw);
        w_placed_inc = {1'b0, r_placed} + (PLACED_W+1)'(1);
        w_fill_now   = w_placed_inc >= (PLACED_W+1)'(w_cells);
        w_cnt_inc    = {1'b0, r_cnt} + (CNT_W+1)'(1);

        w_row = (r_srow >= ROW_W'(r_placed)) ? (r_srow - ROW_W'(r_placed)) : '0;
        w_col = r_scol + COL_W'(r_placed);

        w_slot_free = !r_ovalid || m_axis_tready;
        w_apb_wr    = psel && penable && pwrite && pready;
    end

    // ---------------- control ----------------
    always_comb begin
        n_state    = r_state;
        n_word     = r_word;
        n_pend     = r_pend;
        n_cnt      = r_cnt;
        n_ql       = r_ql;
        n_sl       = r_sl;
        n_diag     = r_diag;
        n_srow     = r_srow;
        n_scol     = r_scol;
        n_placed   = r_placed;
        n_wib      = r_wib;
        n_filled   = r_filled;
        n_err_held = r_err_held;
        n_ovalid   = r_ovalid && !m_axis_tready;
        n_orow     = r_orow;
        n_ocol     = r_ocol;
        n_ocode    = r_ocode;
        n_ostat    = r_ostat;
        n_odone    = r_odone;
        n_olast    = r_olast;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_word = s_axis_tdata;
                    for (int k = 0; k < CODES; k++)
                        n_pend[k] = |s_axis_tdata[CODE_W*k +: CODE_W];
                    n_cnt   = '0;
                    n_state = r_err_held ? S_HERR : S_SCAN;
                end
            end
            S_HERR: begin
                // held overrun leads this word; it is last only when the
                // word has no codes and does not end a one-word block
                if (w_slot_free) begin
                    n_ovalid   = 1'b1;
                    n_orow     = '0;
                    n_ocol     = '0;
                    n_ocode    = '0;
                    n_ostat    = ST_OVERRUN;
                    n_odone    = 1'b0;
                    n_olast    = !((|r_pend) || (w_bw == BLK_W'(1)));
                    n_err_held = 1'b0;
                    n_diag     = DIAG_W'(1);
                    n_srow     = ROW_W'(1);
                    n_scol     = COL_W'(1);
                    n_placed   = '0;
                    n_wib      = '0;
                    n_filled   = 1'b0;
                    n_cnt      = CNT_W'(1);
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_filled || !w_pick.found) begin
                    n_state = S_END;
                end else if (w_slot_free) begin
                    n_ovalid = 1'b1;
                    n_orow   = w_row;
                    n_ocol   = w_col;
                    n_ocode  = w_pick.code;
                    n_ostat  = ST_CELL;
                    n_odone  = w_fill_now && (SUM_W'(r_diag) >= w_last_diag);
                    // last unless more cells or a block overrun follow
                    n_olast  = !((!w_fill_now && w_pick.rest) ||
                                 (w_blk_end && !w_fill_now &&
                                  (w_cnt_inc < (CNT_W+1)'(CODES))));
                    n_pend   = w_pend_next;
                    n_placed = PLACED_W'(w_placed_inc);
                    n_filled = w_fill_now;
                    n_cnt    = CNT_W'(w_cnt_inc);
                end
            end
            S_END: begin
                if (!w_blk_end) begin
                    n_wib   = BLK_W'(w_wib_inc);
                    n_state = S_IDLE;
                end else if (r_filled) begin
                    // next diagonal, or back to the first after the last
                    if (SUM_W'(r_diag) >= w_last_diag) begin
                        n_diag = DIAG_W'(1);
                        n_srow = ROW_W'(1);
                        n_scol = COL_W'(1);
                    end else begin
                        n_diag = r_diag + DIAG_W'(1);
                        if (r_srow < w_eq)
                            n_srow = r_srow + ROW_W'(1);
                        else
                            n_scol = r_scol + COL_W'(1);
                    end
                    n_placed = '0;
                    n_wib    = '0;
                    n_filled = 1'b0;
                    n_state  = S_IDLE;
                end else if (r_cnt == CNT_W'(CODES)) begin
                    // no room in this word: report at the head of the next
                    n_err_held = 1'b1;
                    n_diag     = DIAG_W'(1);
                    n_srow     = ROW_W'(1);
                    n_scol     = COL_W'(1);
                    n_placed   = '0;
                    n_wib      = '0;
                    n_filled   = 1'b0;
                    n_state    = S_IDLE;
                end else if (w_slot_free) begin
                    n_ovalid = 1'b1;
                    n_orow   = '0;
                    n_ocol   = '0;
                    n_ocode  = '0;
                    n_ostat  = ST_OVERRUN;
                    n_odone  = 1'b0;
                    n_olast  = 1'b1;
                    n_diag   = DIAG_W'(1);
                    n_srow   = ROW_W'(1);
                    n_scol   = COL_W'(1);
                    n_placed = '0;
                    n_wib    = '0;
                    n_filled = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // register write: store and restart the matrix
        if (w_apb_wr) begin
            if (paddr[2] == REG_QUERY_LEN)
                n_ql = pwdata[QL_W-1:0];
            else
                n_sl = pwdata[SL_W-1:0];
            n_err_held = 1'b0;
            n_diag     = DIAG_W'(1);
            n_srow     = ROW_W'(1);
            n_scol     = COL_W'(1);
            n_placed   = '0;
            n_wib      = '0;
            n_filled   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_ql       <= QL_W'(1);
            r_sl       <= SL_W'(1);
            r_diag     <= DIAG_W'(1);
            r_srow     <= ROW_W'(1);
            r_scol     <= COL_W'(1);
            r_placed   <= '0;
            r_wib      <= '0;
            r_filled   <= 1'b0;
            r_err_held <= 1'b0;
            r_ovalid   <= 1'b0;
            r_pend     <= '0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_ql       <= n_ql;
            r_sl       <= n_sl;
            r_diag     <= n_diag;
            r_srow     <= n_srow;
            r_scol     <= n_scol;
            r_placed   <= n_placed;
            r_wib      <= n_wib;
            r_filled   <= n_filled;
            r_err_held <= n_err_held;
            r_ovalid   <= n_ovalid;
            r_pend     <= n_pend;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_word  <= n_word;
        r_orow  <= n_orow;
        r_ocol  <= n_ocol;
        r_ocode <= n_ocode;
        r_ostat <= n_ostat;
        r_odone <= n_odone;
        r_olast <= n_olast;
    end

    // ---------------- ports ----------------
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {(OUT_DATA_W - ROW_W - COL_W - CODE_W)'(0), r_ocode, r_ocol, r_orow};
    assign m_axis_tuser  = {r_odone, r_ostat};
    assign m_axis_tlast  = r_olast;
    assign pready        = 1'b1;

    always_comb begin
        if (paddr[2] == REG_QUERY_LEN)
            prdata = APB_DW'(r_ql);
        else
            prdata = APB_DW'(r_sl);
    end

endmodule

// File: rtl/core/dtcu_lane.sv
// ---------------------------------------------------------------------------
// dtcu_lane: per-lane priority search
// Finds the lowest still-pending nonzero code in one slice of the word.
// ---------------------------------------------------------------------------
module dtcu_lane import dtcu_pkg::*; (
    input  logic [CODE_W*LANE_CODES-1:0] i_codes,
    input  logic [LANE_CODES-1:0]        i_pend,
    output t_lane_hit                    o_hit
);

    always_comb begin
        o_hit = '0;
        // descending so the lowest pending code wins
        for (int k = LANE_CODES - 1; k >= 0; k--) begin
            if (i_pend[k]) begin
                o_hit.found = 1'b1;
                o_hit.idx   = LIDX_W'(k);
                o_hit.code  = i_codes[CODE_W*k +: CODE_W];
            end
        end
    end

endmodule

// File: rtl/core/dtcu_merge.sv
// ---------------------------------------------------------------------------
// dtcu_merge: lane merge
// Picks the lowest lane with a hit and updates the pending-code mask.
// ---------------------------------------------------------------------------
module dtcu_merge import dtcu_pkg::*; (
    input  t_lane_hit           i_hits [LANES],
    input  logic [CODES-1:0]    i_pend,
    output t_pick               o_pick,
    output logic [CODES-1:0]    o_pend_next
);

    always_comb begin
        o_pick = '0;
        for (int l = LANES - 1; l >= 0; l--) begin
            if (i_hits[l].found) begin
                o_pick.found = 1'b1;
                o_pick.idx   = IDX_W'(l * LANE_CODES) + IDX_W'(i_hits[l].idx);
                o_pick.code  = i_hits[l].code;
            end
        end
        for (int k = 0; k < CODES; k++) begin
            o_pend_next[k] = i_pend[k] && !(o_pick.found && (o_pick.idx == IDX_W'(k)));
        end
        o_pick.rest = |o_pend_next;
    end

endmodule
